/* rtl/esma_pkg.sv */
package esma_pkg;

    // Field widths
    localparam int COUNT_W = 16;
    localparam int DELTA_W = 17;
    localparam int POS_W   = 32;
    localparam int SPEED_W = 27;
    localparam int SCALE_W = 16;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 80;
    localparam int M_USED_W  = DELTA_W + POS_W + SPEED_W;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd59042;

    // Wrap limits for the raw counter difference (18 bits signed)
    localparam logic signed [COUNT_W+1:0] WRAP_HI   = 18'sd32768;
    localparam logic signed [COUNT_W+1:0] WRAP_LO   = -18'sd32768;
    localparam logic signed [COUNT_W+1:0] WRAP_SPAN = 18'sd65536;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

    // One finished result
    typedef struct packed {
        logic signed [SPEED_W-1:0] avg_speed;
        logic signed [POS_W-1:0]   position;
        logic signed [DELTA_W-1:0] count_delta;
    } result_t;

endpackage

/* rtl/encoder_speed_moving_average.sv */
// Encoder speed by moving average, one motor channel. Each request on the
// s_ side carries one sample of the 16-bit free-running encoder counter. The
// block wraps the change since the previous sample into -32768..32768, adds
// it to a 32-bit wrapping position, keeps the last WINDOW changes in a ring
// with a running sum, and returns (sum * speed_scale) >> 8, floored and
// saturated to 27 bits, as the speed in rpm with 8 fraction bits. One result
// comes out per sample, through the stage 1 registers and then the output
// register. A new sample is taken every cycle while the m_ side is ready:
// the ring and running sum update within the accepting cycle, and the single
// multiply has a stage of its own. The first sample is differenced against zero.
// speed_scale resets to 59042; the user writes it through cfg_we/cfg_wdata only
// while the block is idle, and the block does not enforce this. A second motor is a second instance.
module encoder_speed_moving_average #(
    parameter int WINDOW = 5    // ring length, 1..16
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_we,
    input  logic [esma_pkg::SCALE_W-1:0]   cfg_wdata,   // speed_scale

    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [esma_pkg::S_TDATA_W-1:0] s_tdata,     // [15:0] count_value

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [16:0] count_delta, [48:17] position, [75:49] avg_speed, [79:76] zero
    output logic [esma_pkg::M_TDATA_W-1:0] m_tdata
);
    import esma_pkg::*;

    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = DELTA_W + 1 + $clog2(WINDOW);  // room for WINDOW full-scale deltas
    localparam int PROD_W = SUM_W + SCALE_W + 1;
    localparam int SHR_W  = PROD_W - 8;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

    // ---------------- configuration ----------------
    logic [SCALE_W-1:0] scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
        end else if (cfg_we) begin
            scale_reg <= cfg_wdata;
        end
    end

    // ---------------- handshake ----------------
    // Two-deep pipe: stage 1 (ring update) and the output register.
    logic s1_valid_reg;
    logic m_valid_reg;
    logic out_ready;
    logic s1_ready;
    logic in_accept;

    assign out_ready = !m_valid_reg || m_tready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign s_tready  = s1_ready;
    assign in_accept = s_tvalid && s1_ready;

    // ---------------- stage 1: delta, position, ring ----------------
    logic [COUNT_W-1:0]        last_count_reg;
    logic signed [POS_W-1:0]   position_reg;
    logic signed [SUM_W-1:0]   window_sum_reg;
    logic signed [DELTA_W-1:0] ring_reg [WINDOW];
    logic [IDX_W-1:0]          ring_idx_reg;
    logic signed [DELTA_W-1:0] s1_delta_reg;

    logic [COUNT_W-1:0]          cur_count;
    logic signed [COUNT_W+1:0]   raw_diff;
    logic signed [COUNT_W+1:0]   wrap_diff;
    logic signed [DELTA_W-1:0]   delta_next;
    logic signed [DELTA_W-1:0]   ring_old;
    logic signed [SUM_W-1:0]     window_sum_next;
    logic signed [POS_W-1:0]     position_next;
    logic [IDX_W-1:0]            ring_idx_next;

    assign cur_count = s_tdata[COUNT_W-1:0];
    assign raw_diff  = $signed({2'b00, cur_count}) - $signed({2'b00, last_count_reg});

    always_comb begin
        // exactly +/-32768 stays as is
        if (raw_diff > WRAP_HI) begin
            wrap_diff = raw_diff - WRAP_SPAN;
        end else if (raw_diff < WRAP_LO) begin
            wrap_diff = raw_diff + WRAP_SPAN;
        end else begin
            wrap_diff = raw_diff;
        end
    end

    assign delta_next = wrap_diff[DELTA_W-1:0];
    assign ring_old   = ring_reg[ring_idx_reg];

    assign window_sum_next = window_sum_reg
                           - {{(SUM_W-DELTA_W){ring_old[DELTA_W-1]}}, ring_old}
                           + {{(SUM_W-DELTA_W){delta_next[DELTA_W-1]}}, delta_next};

    assign position_next = position_reg
                         + {{(POS_W-DELTA_W){delta_next[DELTA_W-1]}}, delta_next};

    assign ring_idx_next = (ring_idx_reg == IDX_LAST) ? '0 : ring_idx_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_count_reg <= '0;
            position_reg   <= '0;
            window_sum_reg <= '0;
            ring_idx_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            for (int i = 0; i < WINDOW; i++) begin
                ring_reg[i] <= '0;
            end
        end else begin
            if (in_accept) begin
                last_count_reg         <= cur_count;
                position_reg           <= position_next;
                window_sum_reg         <= window_sum_next;
                ring_reg[ring_idx_reg] <= delta_next;
                ring_idx_reg           <= ring_idx_next;
            end
            if (s1_ready) begin
                s1_valid_reg <= s_tvalid;
            end
        end
    end

    // delta payload; position and sum of the item in stage 1 sit in the
    // state registers, which move only when stage 1 reloads
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_delta_reg <= delta_next;
        end
    end

    // ---------------- stage 2: scale, floor shift, saturate ----------------
    logic signed [PROD_W-1:0]  prod;
    logic signed [SHR_W-1:0]   shifted;
    logic signed [SPEED_W-1:0] speed_sat;
    logic                      over_hi;
    logic                      over_lo;
    result_t                   res_next;
    result_t                   res_reg;

    assign prod    = $signed(window_sum_reg) * $signed({1'b0, scale_reg});
    assign shifted = prod[PROD_W-1:8];   // dropping bits floors

    // out of range when the bits above the result are not a sign extension
    assign over_hi = !shifted[SHR_W-1] && (|shifted[SHR_W-1:SPEED_W-1]);
    assign over_lo =  shifted[SHR_W-1] && !(&shifted[SHR_W-1:SPEED_W-1]);

    always_comb begin
        if (over_hi) begin
            speed_sat = SPEED_MAX;
        end else if (over_lo) begin
            speed_sat = SPEED_MIN;
        end else begin
            speed_sat = shifted[SPEED_W-1:0];
        end
    end

    always_comb begin
        res_next.count_delta = s1_delta_reg;
        res_next.position    = position_reg;
        res_next.avg_speed   = speed_sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && s1_valid_reg) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-M_USED_W){1'b0}}, res_reg};

    // ---------------- assertions ----------------
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_idx_reg <= IDX_LAST)
        else $error("ring index out of range");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && m_valid_reg))
        else $error("input stalled with a free stage");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> s1_valid_reg)
        else $error("accepted request lost in stage 1");

    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_accept |=> $stable(position_reg) && $stable(window_sum_reg))
        else $error("state moved without a request");

    a_s1_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_ready) |=> m_valid_reg)
        else $error("stage 1 result not passed to output");

endmodule
